[hw/rtl/bunif_pkg.sv]
// ----------------------------------------------------------------------------
// bunif_pkg: shared definitions for the block uniformity test
// Field widths, register indexes, finish-sequence constants and the lane
// control group.
// ----------------------------------------------------------------------------
`default_nettype none

package bunif_pkg;

  // Field and register widths
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 28;
  localparam int SQ_W       = 36;
  localparam int TOL_W      = 16;
  localparam int LOG2_W     = 4;
  localparam int SCORE_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Default for the largest supported block exponent
  localparam int MAX_BLOCK_LOG2 = 10;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LOG2 = 1'b1;

  // Divide by three: a scaled total below SCORE_LIMIT fits in QUO_W bits and
  // floor(x / 3) == (x * DIV3_RECIP) >> DIV3_SHIFT for all x < 2^19.
  localparam int                 QUO_W       = 18;
  localparam logic [QUO_W-1:0]   SCORE_LIMIT = 18'd196608;  // 3 * 2^16
  localparam logic [QUO_W-1:0]   DIV3_RECIP  = 18'd174763;  // ceil(2^19 / 3)
  localparam int                 DIV3_SHIFT  = 19;

  // Finish sequence after the last pixel of a block
  localparam int               STEP_W    = 3;
  localparam logic [STEP_W-1:0] LAST_STEP = 3'd5;

  // Lane control group
  typedef struct packed {
    logic acc;   // add the current pixel
    logic clr;   // clear sums after the result is taken over
  } lane_ctrl_t;

  // Width of one channel's deviation: max(n*m^2, Q) plus a carry bit
  function automatic int dev_width(input int max_log2);
    int prod_w;
    prod_w = 2 * PIX_W + 2 * max_log2;
    return ((prod_w > SQ_W) ? prod_w : SQ_W) + 1;
  endfunction

  // Shift amount width for 2 * block_size_log2
  function automatic int shift_width(input int max_log2);
    return $clog2(max_log2 + 1) + 1;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/bunif_lane.sv]
// ----------------------------------------------------------------------------
// bunif_lane: one color channel
// Accumulates sum and sum of squares, then forms the saturated floor mean and
// the clamped squared-deviation total n*m^2 - 2*m*S + Q over three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bunif_lane #(
  parameter int MAX_BLOCK_LOG2 = bunif_pkg::MAX_BLOCK_LOG2
) (
  input  wire                                                clk,
  input  wire                                                rst_n,
  input  wire bunif_pkg::lane_ctrl_t                         ctrl,
  input  wire [bunif_pkg::PIX_W-1:0]                         pixel,
  input  wire [bunif_pkg::shift_width(MAX_BLOCK_LOG2)-1:0]   shift,
  output logic [bunif_pkg::PIX_W-1:0]                        mean,
  output logic [bunif_pkg::dev_width(MAX_BLOCK_LOG2)-1:0]    dev
);

  localparam int PIX_W  = bunif_pkg::PIX_W;
  localparam int SUM_W  = bunif_pkg::SUM_W;
  localparam int SQ_W   = bunif_pkg::SQ_W;
  localparam int DEV_W  = bunif_pkg::dev_width(MAX_BLOCK_LOG2);
  localparam int MSQ_W  = 2 * PIX_W;
  localparam int MS_W   = PIX_W + SUM_W;

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;
  logic [MSQ_W-1:0] pix_sq;
  logic [SUM_W-1:0] quo;
  logic [PIX_W-1:0] mean_r, mean_nxt;
  logic [MSQ_W-1:0] msq_r;
  logic [MS_W-1:0]  ms_r;
  logic [DEV_W-1:0] plus, minus, dev_r, dev_nxt;

  // Accumulators
  assign pix_sq = pixel * pixel;

  always_comb begin
    sum_nxt = sum_r;
    sq_nxt  = sq_r;
    if (ctrl.clr) begin
      sum_nxt = '0;
      sq_nxt  = '0;
    end else if (ctrl.acc) begin
      sum_nxt = sum_r + SUM_W'(pixel);
      sq_nxt  = sq_r + SQ_W'(pix_sq);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      sq_r  <= '0;
    end else begin
      sum_r <= sum_nxt;
      sq_r  <= sq_nxt;
    end
  end

  // Stage 1: floor mean, saturated to 255
  assign quo      = sum_r >> shift;
  assign mean_nxt = (|quo[SUM_W-1:PIX_W]) ? '1 : quo[PIX_W-1:0];

  // Stage 3: n*m^2 + Q - 2*m*S, negative counts as zero
  assign plus    = (DEV_W'(msq_r) << shift) + DEV_W'(sq_r);
  assign minus   = DEV_W'({ms_r, 1'b0});
  assign dev_nxt = (plus >= minus) ? (plus - minus) : '0;

  // Stage registers; sums hold still while the finish runs
  always_ff @(posedge clk) begin
    mean_r <= mean_nxt;
    msq_r  <= mean_r * mean_r;
    ms_r   <= mean_r * sum_r;
    dev_r  <= dev_nxt;
  end

  assign mean = mean_r;
  assign dev  = dev_r;

endmodule

`default_nettype wire

[hw/rtl/bunif_merge.sv]
// ----------------------------------------------------------------------------
// bunif_merge: combines the three channel deviations
// Adds them, divides by 3n (shift, then reciprocal multiply), saturates the
// score and compares it against the tolerance.
// ----------------------------------------------------------------------------
`default_nettype none

module bunif_merge #(
  parameter int MAX_BLOCK_LOG2 = bunif_pkg::MAX_BLOCK_LOG2
) (
  input  wire                                               clk,
  input  wire [bunif_pkg::dev_width(MAX_BLOCK_LOG2)-1:0]    dev_red,
  input  wire [bunif_pkg::dev_width(MAX_BLOCK_LOG2)-1:0]    dev_green,
  input  wire [bunif_pkg::dev_width(MAX_BLOCK_LOG2)-1:0]    dev_blue,
  input  wire [bunif_pkg::shift_width(MAX_BLOCK_LOG2)-1:0]  shift,
  input  wire [bunif_pkg::TOL_W-1:0]                        tolerance,
  output logic [bunif_pkg::SCORE_W-1:0]                     score,
  output logic                                              uniform
);

  localparam int DEV_W   = bunif_pkg::dev_width(MAX_BLOCK_LOG2);
  localparam int TOT_W   = DEV_W + 2;
  localparam int QUO_W   = bunif_pkg::QUO_W;
  localparam int PROD_W  = 2 * QUO_W;
  localparam int SCORE_W = bunif_pkg::SCORE_W;

  logic [TOT_W-1:0]  total, scaled;
  logic              ovf_nxt;
  logic [QUO_W-1:0]  tsc_r;
  logic              ovf1_r, ovf2_r;
  logic [PROD_W-1:0] prod_r;

  // Stage 1: total / n, flag totals whose score exceeds 16 bits
  assign total   = TOT_W'(dev_red) + TOT_W'(dev_green) + TOT_W'(dev_blue);
  assign scaled  = total >> shift;
  assign ovf_nxt = scaled >= TOT_W'(bunif_pkg::SCORE_LIMIT);

  // Stage 2: divide by three through the reciprocal
  always_ff @(posedge clk) begin
    tsc_r  <= scaled[QUO_W-1:0];
    ovf1_r <= ovf_nxt;
    prod_r <= tsc_r * bunif_pkg::DIV3_RECIP;
    ovf2_r <= ovf1_r;
  end

  // Saturate and compare; the unsaturated score over 16 bits never passes
  assign score   = ovf2_r ? '1 : prod_r[bunif_pkg::DIV3_SHIFT +: SCORE_W];
  assign uniform = !ovf2_r && (score <= tolerance);

endmodule

`default_nettype wire

[hw/rtl/block_uniformity_test.sv]
// ----------------------------------------------------------------------------
// block_uniformity_test: homogeneity test for one RGB quadtree block
// Three channel lanes accumulate a block; after the last pixel they form
// means and squared deviations, and a merge stage yields the score.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  in       request    in_valid/in_ready    pixel_red/green/blue, last_pixel
//  out      result     out_valid/out_ready  mean_red/green/blue, score, flag
//  cfg      write      cfg_wr_en            cfg_index, cfg_wdata
//
// Pixels are taken one per cycle. A pixel with last_pixel set starts a
// finish (mean, products, deviation, sum, divide, output load) during
// which in_ready is low; the finish waits longer while a previous
// result is still held in the output register.
// Synchronous active-low reset clears sums, configuration registers and control.
// The output register lets the next block stream in while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module block_uniformity_test #(
  parameter int MAX_BLOCK_LOG2 = bunif_pkg::MAX_BLOCK_LOG2
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // pixel requests
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire [bunif_pkg::PIX_W-1:0]           in_pixel_red,
  input  wire [bunif_pkg::PIX_W-1:0]           in_pixel_green,
  input  wire [bunif_pkg::PIX_W-1:0]           in_pixel_blue,
  input  wire                                  in_last_pixel,
  // results
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [bunif_pkg::PIX_W-1:0]          out_mean_red,
  output logic [bunif_pkg::PIX_W-1:0]          out_mean_green,
  output logic [bunif_pkg::PIX_W-1:0]          out_mean_blue,
  output logic [bunif_pkg::SCORE_W-1:0]        out_deviation_score,
  output logic                                 out_is_uniform,
  // configuration writes
  input  wire                                  cfg_wr_en,
  input  wire [bunif_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [bunif_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int PIX_W   = bunif_pkg::PIX_W;
  localparam int LOG2_W  = bunif_pkg::LOG2_W;
  localparam int TOL_W   = bunif_pkg::TOL_W;
  localparam int SCORE_W = bunif_pkg::SCORE_W;
  localparam int STEP_W  = bunif_pkg::STEP_W;
  localparam int SH_W    = bunif_pkg::shift_width(MAX_BLOCK_LOG2);
  localparam int LG_W    = SH_W - 1;
  localparam int DEV_W   = bunif_pkg::dev_width(MAX_BLOCK_LOG2);

  logic [TOL_W-1:0]    tol_r;
  logic [LOG2_W-1:0]   log2_r;
  logic [LG_W-1:0]     lg_eff;
  logic [SH_W-1:0]     shift;
  logic                in_fire, done;
  logic                busy_r, busy_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  bunif_pkg::lane_ctrl_t lane_ctrl;

  logic [PIX_W-1:0]    mean_red, mean_green, mean_blue;
  logic [DEV_W-1:0]    dev_red, dev_green, dev_blue;
  logic [SCORE_W-1:0]  score;
  logic                uniform;

  logic [PIX_W-1:0]    mean_red_r, mean_green_r, mean_blue_r;
  logic [SCORE_W-1:0]  score_r;
  logic                uniform_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= '0;
      log2_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bunif_pkg::REG_TOLERANCE:  tol_r  <= cfg_wdata[TOL_W-1:0];
        bunif_pkg::REG_BLOCK_LOG2: log2_r <= cfg_wdata[LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the exponent; shift by 2*lg divides by n = 4^lg
  assign lg_eff = (log2_r > LOG2_W'(MAX_BLOCK_LOG2)) ? LG_W'(MAX_BLOCK_LOG2)
                                                     : log2_r[LG_W-1:0];
  assign shift  = {lg_eff, 1'b0};

  // Handshake and finish sequencing
  assign in_ready = !busy_r;
  assign in_fire  = in_valid && in_ready;
  assign done     = busy_r && (step_r == bunif_pkg::LAST_STEP) &&
                    (!out_valid_r || out_ready);

  always_comb begin
    busy_nxt = busy_r;
    if (in_fire && in_last_pixel) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    if (!busy_r || done) begin
      step_nxt = '0;
    end else if (step_r != bunif_pkg::LAST_STEP) begin
      step_nxt = step_r + STEP_W'(1);
    end else begin
      step_nxt = step_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign lane_ctrl.acc = in_fire;
  assign lane_ctrl.clr = done;

  // Channel lanes
  bunif_lane #(.MAX_BLOCK_LOG2(MAX_BLOCK_LOG2)) u_lane_red (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (lane_ctrl),
    .pixel (in_pixel_red),
    .shift (shift),
    .mean  (mean_red),
    .dev   (dev_red)
  );

  bunif_lane #(.MAX_BLOCK_LOG2(MAX_BLOCK_LOG2)) u_lane_green (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (lane_ctrl),
    .pixel (in_pixel_green),
    .shift (shift),
    .mean  (mean_green),
    .dev   (dev_green)
  );

  bunif_lane #(.MAX_BLOCK_LOG2(MAX_BLOCK_LOG2)) u_lane_blue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (lane_ctrl),
    .pixel (in_pixel_blue),
    .shift (shift),
    .mean  (mean_blue),
    .dev   (dev_blue)
  );

  // Merge of the channel deviations
  bunif_merge #(.MAX_BLOCK_LOG2(MAX_BLOCK_LOG2)) u_merge (
    .clk       (clk),
    .dev_red   (dev_red),
    .dev_green (dev_green),
    .dev_blue  (dev_blue),
    .shift     (shift),
    .tolerance (tol_r),
    .score     (score),
    .uniform   (uniform)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (done) begin
      mean_red_r   <= mean_red;
      mean_green_r <= mean_green;
      mean_blue_r  <= mean_blue;
      score_r      <= score;
      uniform_r    <= uniform;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mean_red        = mean_red_r;
  assign out_mean_green      = mean_green_r;
  assign out_mean_blue       = mean_blue_r;
  assign out_deviation_score = score_r;
  assign out_is_uniform      = uniform_r;

  // Assertions
  a_last_starts_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_pixel) |=> (busy_r && step_r == '0))
    else $error("last pixel did not start the finish sequence");

  a_finish_not_early: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && step_r != bunif_pkg::LAST_STEP) |=> busy_r)
    else $error("finish sequence ended before its last step");

  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (out_valid_r && !busy_r))
    else $error("finished result not presented");

  a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> step_r == '0)
    else $error("step counter running while idle");

endmodule

`default_nettype wire

[verif/block_uniformity_test_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_uniformity_test_tb: self-checking bench for the block uniformity test
// Streams RGB pixel blocks in under random idle gaps and result stalls, works
// out the channel means, deviation score and uniform flag of every block in a
// scoreboard, and checks each result in order. Both registers are swept
// between phases, including the zero, largest and oversized settings.
// ----------------------------------------------------------------------------
module block_uniformity_test_tb;

  localparam int PIX_W          = bunif_pkg::PIX_W;
  localparam int SUM_W          = bunif_pkg::SUM_W;
  localparam int SQ_W           = bunif_pkg::SQ_W;
  localparam int TOL_W          = bunif_pkg::TOL_W;
  localparam int LOG2_W         = bunif_pkg::LOG2_W;
  localparam int SCORE_W        = bunif_pkg::SCORE_W;
  localparam int CFG_IDX_W      = bunif_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W     = bunif_pkg::CFG_DATA_W;
  localparam int MAX_BLOCK_LOG2 = bunif_pkg::MAX_BLOCK_LOG2;
  localparam int UPPER_W        = CFG_DATA_W - LOG2_W;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_GAP       = 13;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_PIXELS = 500;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [2:0][PIX_W-1:0] rgb;    // 0 red, 1 green, 2 blue
    logic                  last;
  } pixel_t;

  typedef struct packed {
    logic [2:0][PIX_W-1:0] mean;
    logic [SCORE_W-1:0]    score;
    logic                  uniform;
  } block_result_t;

  typedef enum int {FILL_RANDOM, FILL_FLAT, FILL_NOISY, FILL_EXTREME} fill_t;

  // Running block statistics and the queue of block results still owed
  class block_result_tracker;
    logic [TOL_W-1:0]  tolerance;
    logic [LOG2_W-1:0] block_log2;
    logic [SUM_W-1:0]  chan_sum [3];
    logic [SQ_W-1:0]   chan_sq  [3];
    block_result_t     pending_results [$];
    int                failures;
    int                pixels_seen;
    int                blocks_checked;
    int                uniform_blocks;

    function new();
      tolerance      = '0;
      block_log2     = '0;
      failures       = 0;
      pixels_seen    = 0;
      blocks_checked = 0;
      uniform_blocks = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      foreach (chan_sum[c]) begin
        chan_sum[c] = '0;
        chan_sq[c]  = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == bunif_pkg::REG_TOLERANCE) tolerance = data[TOL_W-1:0];
      else block_log2 = data[LOG2_W-1:0];
    endfunction

    // Accumulate one accepted pixel; the last pixel of a block owes a result
    function void add_pixel(pixel_t px);
      block_result_t   want;
      longint unsigned eff_log2, n, m, s, plus, minus, total, score;
      pixels_seen++;
      for (int c = 0; c < 3; c++) begin
        chan_sum[c] = chan_sum[c] + px.rgb[c];        // wraps at 28 bits
        chan_sq[c]  = chan_sq[c] + px.rgb[c] * px.rgb[c];  // wraps at 36 bits
      end
      if (!px.last) return;

      eff_log2 = (block_log2 > MAX_BLOCK_LOG2) ? MAX_BLOCK_LOG2 : block_log2;
      n        = 64'd1 << (2 * eff_log2);
      total    = 0;
      for (int c = 0; c < 3; c++) begin
        s = chan_sum[c];
        m = s / n;
        if (m > 255) m = 255;
        // n*m^2 - 2*m*S + Q, negative totals count as zero
        plus  = n * m * m + chan_sq[c];
        minus = 2 * m * s;
        if (plus >= minus) total += plus - minus;
        want.mean[c] = m[PIX_W-1:0];
      end
      score        = total / (3 * n);
      want.score   = (score > 64'hFFFF) ? '1 : score[SCORE_W-1:0];
      want.uniform = (score <= tolerance);
      pending_results.push_back(want);
      clear_sums();
    endfunction

    function void check_result(block_result_t got);
      block_result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("ERROR @%0t: unexpected result mean %0d/%0d/%0d score %0d uniform %0b",
                   $time, got.mean[0], got.mean[1], got.mean[2], got.score, got.uniform);
        return;
      end
      want = pending_results.pop_front();
      blocks_checked++;
      if (want.uniform) uniform_blocks++;
      if (got.mean[0] !== want.mean[0] || got.mean[1] !== want.mean[1] ||
          got.mean[2] !== want.mean[2] || got.score !== want.score ||
          got.uniform !== want.uniform) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("ERROR @%0t: block %0d mean %0d/%0d/%0d score %0d uniform %0b",
                   $time, blocks_checked, got.mean[0], got.mean[1], got.mean[2],
                   got.score, got.uniform);
          $display("       expected mean %0d/%0d/%0d score %0d uniform %0b",
                   want.mean[0], want.mean[1], want.mean[2], want.score, want.uniform);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_pixel_red;
  logic [PIX_W-1:0]      in_pixel_green;
  logic [PIX_W-1:0]      in_pixel_blue;
  logic                  in_last_pixel;
  logic                  out_valid;
  logic                  out_ready;
  logic [PIX_W-1:0]      out_mean_red;
  logic [PIX_W-1:0]      out_mean_green;
  logic [PIX_W-1:0]      out_mean_blue;
  logic [SCORE_W-1:0]    out_deviation_score;
  logic                  out_is_uniform;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  block_result_tracker tracker;
  int                  cycle_count = 0;
  int                  send_gap_max = MAX_GAP;
  bit                  hold_request = 1'b0;
  int                  holds_done = 0;
  int                  settings_used = 0;

  block_uniformity_test i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pixel_red        (in_pixel_red),
    .in_pixel_green      (in_pixel_green),
    .in_pixel_blue       (in_pixel_blue),
    .in_last_pixel       (in_last_pixel),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_mean_red        (out_mean_red),
    .out_mean_green      (out_mean_green),
    .out_mean_blue       (out_mean_blue),
    .out_deviation_score (out_deviation_score),
    .out_is_uniform      (out_is_uniform),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: watchdog expired, %0d block results outstanding",
               tracker.pending_results.size());
      $display("FAIL block_uniformity_test");
      $finish;
    end
  end

  function automatic pixel_t pixel_of(int r, int g, int b, bit last);
    pixel_t px;
    px.rgb[0] = PIX_W'(r);
    px.rgb[1] = PIX_W'(g);
    px.rgb[2] = PIX_W'(b);
    px.last   = last;
    return px;
  endfunction

  function automatic pixel_t make_pixel(fill_t fill, logic [2:0][PIX_W-1:0] base, bit last);
    pixel_t px;
    int     v;
    px.last = last;
    for (int c = 0; c < 3; c++) begin
      case (fill)
        FILL_RANDOM:  px.rgb[c] = PIX_W'($urandom_range(0, 255));
        FILL_FLAT:    px.rgb[c] = base[c];
        FILL_NOISY: begin
          v = int'(base[c]) + int'($urandom_range(0, 6)) - 3;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          px.rgb[c] = PIX_W'(v);
        end
        default:      px.rgb[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
    end
    return px;
  endfunction

  // Offer one pixel request and hold it until the block takes it
  task automatic send_pixel(input pixel_t px);
    int gap;
    bit taken;
    gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_red   <= px.rgb[0];
    in_pixel_green <= px.rgb[1];
    in_pixel_blue  <= px.rgb[2];
    in_last_pixel  <= px.last;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (in_ready === 1'b1);
      @(posedge clk);
    end
    tracker.add_pixel(px);
  endtask

  task automatic send_block(input int count);
    fill_t                 fill;
    logic [2:0][PIX_W-1:0] base;
    fill = fill_t'($urandom_range(0, 3));
    base = 24'($urandom);
    for (int i = 0; i < count; i++)
      send_pixel(make_pixel(fill, base, i == count - 1));
  endtask

  // Stop sending and let every owed result come back before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [TOL_W-1:0] tol, input logic [CFG_DATA_W-1:0] log2_word);
    cfg_wr_en <= 1'b1;
    cfg_index <= bunif_pkg::REG_TOLERANCE;
    cfg_wdata <= CFG_DATA_W'(tol);
    @(posedge clk);
    tracker.write_reg(bunif_pkg::REG_TOLERANCE, CFG_DATA_W'(tol));
    cfg_index <= bunif_pkg::REG_BLOCK_LOG2;
    cfg_wdata <= log2_word;
    @(posedge clk);
    tracker.write_reg(bunif_pkg::REG_BLOCK_LOG2, log2_word);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Result side: random stalls, quiet stretches and the long hold-off
  initial begin : result_sink
    block_result_t got;
    int            gap;
    int            recv_gap_max;
    int            until_toggle;
    bit            taken;
    out_ready    <= 1'b0;
    recv_gap_max = MAX_GAP;
    until_toggle = 20;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        holds_done++;
      end else begin
        gap = (recv_gap_max > 0) ? $urandom_range(0, recv_gap_max) : 0;
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk);
        taken       = (out_valid === 1'b1);
        got.mean[0] = out_mean_red;
        got.mean[1] = out_mean_green;
        got.mean[2] = out_mean_blue;
        got.score   = out_deviation_score;
        got.uniform = out_is_uniform;
        @(posedge clk);
      end
      tracker.check_result(got);
      until_toggle--;
      if (until_toggle == 0) begin
        recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
        until_toggle = $urandom_range(8, 40);
      end
    end
  end

  // Main sequence
  initial begin
    int                    sel;
    int                    lg;
    int                    full;
    int                    count;
    int                    nblocks;
    int                    random_pixels;
    logic [TOL_W-1:0]      tol;
    logic [CFG_DATA_W-1:0] log2_word;

    tracker        = new();
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_pixel_red   <= '0;
    in_pixel_green <= '0;
    in_pixel_blue  <= '0;
    in_last_pixel  <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= bunif_pkg::REG_TOLERANCE;
    cfg_wdata      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-pixel blocks: extremes, saturated means, negative deviation
    configure(16'd0, 16'd0);
    send_pixel(pixel_of(0, 0, 0, 1));
    send_pixel(pixel_of(255, 255, 255, 1));
    send_pixel(pixel_of(170, 85, 15, 1));
    send_pixel(pixel_of(255, 255, 255, 0));     // two pixels into n = 1
    send_pixel(pixel_of(255, 128, 1, 1));       // means saturate to 255
    send_pixel(pixel_of(200, 200, 200, 0));
    send_pixel(pixel_of(200, 200, 200, 1));     // deviation goes negative
    drain();

    // Oversized exponent is capped at the largest block
    configure(16'hFFFF, 16'hFFFF);
    send_pixel(pixel_of(255, 0, 128, 0));
    send_pixel(pixel_of(0, 255, 1, 0));
    send_pixel(pixel_of(255, 255, 254, 1));
    drain();
    configure(16'd1, 16'(MAX_BLOCK_LOG2));
    send_pixel(pixel_of(1, 2, 3, 0));
    send_pixel(pixel_of(254, 253, 252, 1));
    drain();

    // 2x2 blocks: flat, checkerboard, and a short block
    configure(16'd100, 16'd1);
    for (int i = 0; i < 4; i++) send_pixel(pixel_of(17, 34, 51, i == 3));
    for (int i = 0; i < 4; i++)
      send_pixel(pixel_of((i % 2) ? 255 : 0, (i % 2) ? 0 : 255, (i < 2) ? 0 : 255, i == 3));
    send_pixel(pixel_of(9, 99, 199, 0));
    send_pixel(pixel_of(9, 99, 199, 1));
    drain();

    // Back-to-back single-pixel blocks against a long result hold-off
    configure(16'd0, 16'd0);
    send_gap_max = 0;
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) send_block(1);
    drain();

    // Random phases, mostly whole blocks of the programmed size
    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) lg = 0;
      else if (sel < 50) lg = 1;
      else if (sel < 75) lg = 2;
      else if (sel < 90) lg = 3;
      else if (sel < 93) lg = 4;
      else lg = $urandom_range(5, 15);

      sel = $urandom_range(0, 9);
      if (sel == 0) tol = '0;
      else if (sel == 1) tol = '1;
      else if (sel == 2) tol = TOL_W'($urandom);
      else tol = TOL_W'($urandom_range(0, 400));

      log2_word = CFG_DATA_W'(lg);
      if ($urandom_range(0, 2) == 0) log2_word[CFG_DATA_W-1:LOG2_W] = UPPER_W'($urandom);
      configure(tol, log2_word);

      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      nblocks      = (lg == 4) ? 1 : $urandom_range(1, 6);
      for (int b = 0; b < nblocks; b++) begin
        full = (lg <= 4) ? (1 << (2 * lg)) : 0;
        if (full > 0 && $urandom_range(0, 99) < 85) count = full;
        else if (full > 0) count = $urandom_range(1, (2 * full < 24) ? 2 * full : 24);
        else count = $urandom_range(1, 24);
        send_block(count);
        random_pixels += count;
      end
      drain();
    end

    $display("Covered %0d pixels in %0d blocks (%0d uniform) over %0d register settings",
             tracker.pixels_seen, tracker.blocks_checked, tracker.uniform_blocks,
             settings_used);
    $display("Exponents 0 to 15, short and long blocks, %0d long result hold-off(s)",
             holds_done);
    if (tracker.failures == 0) begin
      $display("PASS block_uniformity_test");
    end else begin
      $display("%0d failure(s)", tracker.failures);
      $display("FAIL block_uniformity_test");
    end
    $finish;
  end

endmodule
